/* hdl/htc_pkg.sv */
// shared types and constants for the humidity/temperature calibration block
`timescale 1ns / 1ps

package htc_pkg;

  localparam int FRAC_BITS_DEFAULT = 6;

  localparam int RAW_W  = 16;
  localparam int OUT_W  = 24;
  localparam int QUO_W  = OUT_W;
  localparam int DIFF_W = RAW_W + 1;
  localparam int REF_W  = 10;
  localparam int DREF_W = REF_W + 1;
  localparam int PROD_W = DIFF_W + DREF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  localparam int TEMP_SCALE_LOG2 = 3;
  localparam int HUM_SCALE_LOG2  = 1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    CMD_TEMP,
    CMD_HUM
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DEN_ZERO,
    ST_SAT
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_HUM_REF0,
    REG_HUM_REF1,
    REG_TEMP_REF0,
    REG_TEMP_REF1,
    REG_HUM_RAW0,
    REG_HUM_RAW1,
    REG_TEMP_RAW0,
    REG_TEMP_RAW1
  } reg_idx_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [RAW_W-1:0]  raw_sample;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  scaled_value;
    status_t                  status;
  } out_t;

  typedef struct packed {
    logic [REF_W-1:0]         ref0;
    logic [REF_W-1:0]         ref1;
    logic signed [RAW_W-1:0]  raw0;
    logic signed [RAW_W-1:0]  raw1;
  } cal_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } num_flags_t;

  typedef struct packed {
    logic             zero;
    logic             neg;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

/* hdl/htc_stream_if.sv */
// valid/ready stream channel carrying one payload type
`timescale 1ns / 1ps

interface htc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/htc_cal_regs.sv */
// calibration register file and per-command selection of the calibration points
`timescale 1ns / 1ps

module htc_cal_regs
  import htc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  cmd_t             command,
  output cal_t             cal
);

  logic [7:0]              hum_ref0_x2;
  logic [7:0]              hum_ref1_x2;
  logic [REF_W-1:0]        temp_ref0_x8;
  logic [REF_W-1:0]        temp_ref1_x8;
  logic signed [RAW_W-1:0] hum_raw0;
  logic signed [RAW_W-1:0] hum_raw1;
  logic signed [RAW_W-1:0] temp_raw0;
  logic signed [RAW_W-1:0] temp_raw1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hum_ref0_x2  <= '0;
      hum_ref1_x2  <= '0;
      temp_ref0_x8 <= '0;
      temp_ref1_x8 <= '0;
      hum_raw0     <= '0;
      hum_raw1     <= '0;
      temp_raw0    <= '0;
      temp_raw1    <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HUM_REF0:  hum_ref0_x2  <= cfg_wr_data[7:0];
        REG_HUM_REF1:  hum_ref1_x2  <= cfg_wr_data[7:0];
        REG_TEMP_REF0: temp_ref0_x8 <= cfg_wr_data[REF_W-1:0];
        REG_TEMP_REF1: temp_ref1_x8 <= cfg_wr_data[REF_W-1:0];
        REG_HUM_RAW0:  hum_raw0     <= cfg_wr_data;
        REG_HUM_RAW1:  hum_raw1     <= cfg_wr_data;
        REG_TEMP_RAW0: temp_raw0    <= cfg_wr_data;
        REG_TEMP_RAW1: temp_raw1    <= cfg_wr_data;
      endcase
    end
  end

  always_comb begin
    if (command == CMD_HUM) begin
      cal.ref0 = {{(REF_W-8){1'b0}}, hum_ref0_x2};
      cal.ref1 = {{(REF_W-8){1'b0}}, hum_ref1_x2};
      cal.raw0 = hum_raw0;
      cal.raw1 = hum_raw1;
    end else begin
      cal.ref0 = temp_ref0_x8;
      cal.ref1 = temp_ref1_x8;
      cal.raw0 = temp_raw0;
      cal.raw1 = temp_raw1;
    end
  end

endmodule

/* hdl/htc_numer.sv */
// three-stage numerator pipeline: differences, products, sum and magnitudes
`timescale 1ns / 1ps

module htc_numer
  import htc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        up_valid,
  output logic                                        up_ready,
  input  in_t                                         up_data,
  input  cal_t                                        cal,
  output logic                                        dn_valid,
  input  logic                                        dn_ready,
  output logic [SUM_W+FRAC_BITS-HUM_SCALE_LOG2-1:0]   dn_mag_n,
  output logic [RAW_W-1:0]                            dn_mag_d,
  output num_flags_t                                  dn_flags
);

  localparam int NUM_W    = SUM_W + FRAC_BITS - HUM_SCALE_LOG2;
  localparam int HUM_SH   = FRAC_BITS - HUM_SCALE_LOG2;
  localparam int TEMP_SH  = FRAC_BITS - TEMP_SCALE_LOG2;

  // stage a
  logic                     vld_a;
  logic                     rdy_a;
  logic signed [DIFF_W-1:0] a_xm;
  logic signed [DIFF_W-1:0] a_d;
  logic signed [DREF_W-1:0] a_dref;
  logic [REF_W-1:0]         a_ref0;
  cmd_t                     a_cmd;

  // stage b
  logic                     vld_b;
  logic                     rdy_b;
  logic signed [PROD_W-1:0] b_p1;
  logic signed [PROD_W-1:0] b_p2;
  logic signed [DIFF_W-1:0] b_d;
  logic                     b_zero;
  cmd_t                     b_cmd;

  // stage c
  logic                     vld_c;
  logic                     rdy_c;

  logic signed [DIFF_W-1:0] xm_in;
  logic signed [DIFF_W-1:0] d_in;
  logic signed [DREF_W-1:0] dref_in;
  logic signed [SUM_W-1:0]  sum_b;
  logic [NUM_W-1:0]         ext_b;
  logic [NUM_W-1:0]         shifted_b;
  logic [NUM_W-1:0]         mag_n_b;
  logic [DIFF_W-1:0]        abs_d_b;

  assign rdy_c    = !vld_c || dn_ready;
  assign rdy_b    = !vld_b || rdy_c;
  assign rdy_a    = !vld_a || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vld_c;

  assign xm_in   = {up_data.raw_sample[RAW_W-1], up_data.raw_sample}
                 - {cal.raw0[RAW_W-1], cal.raw0};
  assign d_in    = {cal.raw1[RAW_W-1], cal.raw1} - {cal.raw0[RAW_W-1], cal.raw0};
  assign dref_in = {1'b0, cal.ref1} - {1'b0, cal.ref0};

  assign sum_b     = {b_p1[PROD_W-1], b_p1} + {b_p2[PROD_W-1], b_p2};
  assign ext_b     = {{(NUM_W-SUM_W){sum_b[SUM_W-1]}}, sum_b};
  assign shifted_b = (b_cmd == CMD_HUM) ? (ext_b << HUM_SH) : (ext_b << TEMP_SH);
  assign mag_n_b   = shifted_b[NUM_W-1] ? (~shifted_b + 1'b1) : shifted_b;
  assign abs_d_b   = b_d[DIFF_W-1] ? (~b_d + 1'b1) : b_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a <= up_valid;
      end
      if (rdy_b) begin
        vld_b <= vld_a;
      end
      if (rdy_c) begin
        vld_c <= vld_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_xm   <= xm_in;
      a_d    <= d_in;
      a_dref <= dref_in;
      a_ref0 <= cal.ref0;
      a_cmd  <= up_data.command;
    end
    if (rdy_b) begin
      b_p1   <= a_xm * a_dref;
      b_p2   <= $signed({1'b0, a_ref0}) * a_d;
      b_d    <= a_d;
      b_zero <= (a_d == '0);
      b_cmd  <= a_cmd;
    end
    if (rdy_c) begin
      dn_mag_n      <= mag_n_b;
      dn_mag_d      <= abs_d_b[RAW_W-1:0];
      dn_flags.zero <= b_zero;
      dn_flags.neg  <= shifted_b[NUM_W-1] ^ b_d[DIFF_W-1];
    end
  end

endmodule

/* hdl/htc_divider.sv */
// pipelined restoring divider: overflow check stage then one quotient bit per stage
`timescale 1ns / 1ps

module htc_divider
  import htc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      up_valid,
  output logic                                      up_ready,
  input  logic [SUM_W+FRAC_BITS-HUM_SCALE_LOG2-1:0] up_mag_n,
  input  logic [RAW_W-1:0]                          up_mag_d,
  input  num_flags_t                                up_flags,
  output logic                                      dn_valid,
  input  logic                                      dn_ready,
  output div_res_t                                  dn_res
);

  localparam int NUM_W = SUM_W + FRAC_BITS - HUM_SCALE_LOG2;
  localparam int CMP_W = RAW_W + 1;

  logic             vld   [0:QUO_W];
  logic             rdy   [0:QUO_W];
  logic             zero  [0:QUO_W];
  logic             neg   [0:QUO_W];
  logic             ovf   [0:QUO_W];
  logic [QUO_W-1:0] quo   [0:QUO_W];
  logic [NUM_W-1:0] rem   [0:QUO_W-1];
  logic [RAW_W-1:0] mag_d [0:QUO_W-1];

  assign up_ready = rdy[0];
  assign dn_valid = vld[QUO_W];
  assign dn_res   = '{zero: zero[QUO_W], neg: neg[QUO_W], ovf: ovf[QUO_W], quo: quo[QUO_W]};

  // quotient of 2^QUO_W or more cannot be represented
  assign rdy[0] = !vld[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      zero[0]  <= up_flags.zero;
      neg[0]   <= up_flags.neg;
      ovf[0]   <= (up_mag_n >> QUO_W) >= NUM_W'(up_mag_d);
      quo[0]   <= '0;
      rem[0]   <= up_mag_n;
      mag_d[0] <= up_mag_d;
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_bit
    localparam int BIT = QUO_W - s;

    logic [NUM_W-1:0] hi;
    logic             ge;

    if (s < QUO_W) begin : g_rdy_mid
      assign rdy[s] = !vld[s] || rdy[s+1];
    end else begin : g_rdy_last
      assign rdy[s] = !vld[s] || dn_ready;
    end

    assign hi = rem[s-1] >> BIT;
    assign ge = hi[CMP_W-1:0] >= {1'b0, mag_d[s-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        zero[s] <= zero[s-1];
        neg[s]  <= neg[s-1];
        ovf[s]  <= ovf[s-1];
        quo[s]  <= quo[s-1] | (QUO_W'(ge) << BIT);
      end
    end

    if (s < QUO_W) begin : g_rem
      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          rem[s]   <= ge ? (rem[s-1] - (NUM_W'(mag_d[s-1]) << BIT)) : rem[s-1];
          mag_d[s] <= mag_d[s-1];
        end
      end
    end
  end

endmodule

/* hdl/htc_sat.sv */
// sign restore, saturation and status coding into the output register
`timescale 1ns / 1ps

module htc_sat
  import htc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  div_res_t up_res,
  output logic     dn_valid,
  input  logic     dn_ready,
  output out_t     dn_data
);

  logic                    pos_sat;
  logic                    neg_sat;
  out_t                    res_next;

  assign up_ready = !dn_valid || dn_ready;

  assign pos_sat = !up_res.neg && up_res.quo[QUO_W-1];
  assign neg_sat = up_res.neg && up_res.quo[QUO_W-1] && (|up_res.quo[QUO_W-2:0]);

  always_comb begin
    priority if (up_res.zero) begin
      res_next.scaled_value = '0;
      res_next.status       = ST_DEN_ZERO;
    end else if (up_res.ovf || pos_sat || neg_sat) begin
      res_next.scaled_value = up_res.neg ? OUT_MIN : OUT_MAX;
      res_next.status       = ST_SAT;
    end else begin
      res_next.scaled_value = up_res.neg ? $signed(~up_res.quo + 1'b1) : $signed(up_res.quo);
      res_next.status       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= res_next;
    end
  end

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    dn_valid && dn_data.status == ST_DEN_ZERO |-> dn_data.scaled_value == '0)
    else $error("zero denominator result not cleared");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    dn_valid && dn_data.status == ST_SAT |->
      dn_data.scaled_value == OUT_MAX || dn_data.scaled_value == OUT_MIN)
    else $error("saturated result not at a bound");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> dn_data.status == ST_OK || dn_data.status == ST_DEN_ZERO ||
                 dn_data.status == ST_SAT)
    else $error("undefined status code");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready && up_res.zero |=> dn_valid && dn_data.status == ST_DEN_ZERO)
    else $error("zero denominator flag lost");

endmodule

/* hdl/humidity_temperature_calibration_top.sv */
// top level: two-point linear calibration of temperature and humidity samples
// throughput: one transaction per cycle while out_chan.ready is not held low;
//   3 numerator stages, 1 overflow stage, 24 divider stages (one quotient bit each)
//   and the output register
// reset: synchronous, clears all pipeline valid bits and calibration registers to 0
`timescale 1ns / 1ps

module humidity_temperature_calibration_top
  import htc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  htc_stream_if.sink       in_chan,
  htc_stream_if.source     out_chan,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int NUM_W = SUM_W + FRAC_BITS - HUM_SCALE_LOG2;

  in_t              in_data;
  cal_t             cal;
  logic             num_valid;
  logic             num_ready;
  logic [NUM_W-1:0] num_mag_n;
  logic [RAW_W-1:0] num_mag_d;
  num_flags_t       num_flags;
  logic             div_valid;
  logic             div_ready;
  div_res_t         div_res;
  out_t             out_data;

  assign in_data       = in_chan.data;
  assign out_chan.data = out_data;

  htc_cal_regs u_cal_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .command     (in_data.command),
    .cal         (cal)
  );

  htc_numer #(
    .FRAC_BITS (FRAC_BITS)
  ) u_numer (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_data  (in_data),
    .cal      (cal),
    .dn_valid (num_valid),
    .dn_ready (num_ready),
    .dn_mag_n (num_mag_n),
    .dn_mag_d (num_mag_d),
    .dn_flags (num_flags)
  );

  htc_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .up_valid (num_valid),
    .up_ready (num_ready),
    .up_mag_n (num_mag_n),
    .up_mag_d (num_mag_d),
    .up_flags (num_flags),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_res   (div_res)
  );

  htc_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_res   (div_res),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_data  (out_data)
  );

endmodule

/* verif/humidity_temperature_calibration_top_tb.sv */
// self-checking testbench for the two-point temperature/humidity calibration block
`timescale 1ns / 1ps

module humidity_temperature_calibration_top_tb
  import htc_pkg::*;
;

  localparam int FRAC_BITS    = FRAC_BITS_DEFAULT;
  localparam int PIPE_LATENCY = 29;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 242;
  localparam int PRINT_CAP    = 200;

  class cal_scoreboard #(int FRAC = FRAC_BITS_DEFAULT);
    cal_t temp_cal;
    cal_t hum_cal;
    out_t expected_results[$];
    int   errors;

    function new();
      temp_cal = '0;
      hum_cal  = '0;
      errors   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_HUM_REF0:  hum_cal.ref0 = {2'b00, data[7:0]};
        REG_HUM_REF1:  hum_cal.ref1 = {2'b00, data[7:0]};
        REG_TEMP_REF0: temp_cal.ref0 = data[REF_W-1:0];
        REG_TEMP_REF1: temp_cal.ref1 = data[REF_W-1:0];
        REG_HUM_RAW0:  hum_cal.raw0 = data;
        REG_HUM_RAW1:  hum_cal.raw1 = data;
        REG_TEMP_RAW0: temp_cal.raw0 = data;
        REG_TEMP_RAW1: temp_cal.raw1 = data;
        default: ;
      endcase
    endfunction

    function out_t convert_sample(in_t s);
      cal_t   c;
      longint x, r0, r1, ref0, ref1, d, num, den, q, scale;
      out_t   r;
      if (s.command == CMD_TEMP) begin
        c     = temp_cal;
        scale = longint'(1) << TEMP_SCALE_LOG2;
      end else begin
        c     = hum_cal;
        scale = longint'(1) << HUM_SCALE_LOG2;
      end
      x    = longint'(s.raw_sample);
      r0   = longint'(c.raw0);
      r1   = longint'(c.raw1);
      ref0 = longint'({1'b0, c.ref0});
      ref1 = longint'({1'b0, c.ref1});
      d    = r1 - r0;
      r.scaled_value = '0;
      r.status       = ST_OK;
      if (d == 0) begin
        r.status = ST_DEN_ZERO;
      end else begin
        num = ((x - r0) * (ref1 - ref0) + ref0 * d) * (longint'(1) << FRAC);
        den = d * scale;
        q   = num / den;
        if (q > longint'(OUT_MAX)) begin
          q        = longint'(OUT_MAX);
          r.status = ST_SAT;
        end else if (q < longint'(OUT_MIN)) begin
          q        = longint'(OUT_MIN);
          r.status = ST_SAT;
        end
        r.scaled_value = q[OUT_W-1:0];
      end
      return r;
    endfunction

    function void note_sample(in_t s);
      expected_results.push_back(convert_sample(s));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t exp_r;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected transaction value=%0d status=%0d",
                         got.scaled_value, got.status));
      end else begin
        exp_r = expected_results.pop_front();
        if (got.scaled_value !== exp_r.scaled_value)
          report($sformatf("scaled_value got %0d want %0d",
                           got.scaled_value, exp_r.scaled_value));
        if (got.status !== exp_r.status)
          report($sformatf("status got %0d want %0d", got.status, exp_r.status));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wr_data;
  logic [CFG_W-1:0] cal_words [8];
  logic             no_idle;
  int               cycle_count;

  htc_stream_if #(.T(in_t))  in_chan ();
  htc_stream_if #(.T(out_t)) out_chan ();

  cal_scoreboard #(FRAC_BITS) sb;

  humidity_temperature_calibration_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_chan.valid && in_chan.ready) sb.note_sample(in_chan.data);
      if (out_chan.valid && out_chan.ready) sb.check_result(out_chan.data);
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      @(negedge clk);
    end
  end

  task send_sample(cmd_t cmd, logic [RAW_W-1:0] raw);
    int   gap;
    in_t  s;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s.command    = cmd;
    s.raw_sample = raw;
    in_chan.valid <= 1'b1;
    in_chan.data  <= s;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task wait_drain();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task apply_cal(logic [CFG_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= reg_idx_t'(i);
      cfg_wr_data <= vals[i];
      cal_words[i] = vals[i];
      sb.write_reg(reg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task random_cal();
    logic [CFG_W-1:0] vals [8];
    int mode;
    for (int i = 0; i < 4; i++) vals[i] = CFG_W'($urandom_range(0, 65535));
    for (int p = 0; p < 2; p++) begin
      vals[4 + 2 * p] = CFG_W'($urandom_range(0, 65535));
      mode = $urandom_range(0, 7);
      if (mode == 0)
        vals[5 + 2 * p] = vals[4 + 2 * p];
      else if (mode < 3)
        vals[5 + 2 * p] = CFG_W'(vals[4 + 2 * p] + $urandom_range(1, 8) - 4 * (mode - 1));
      else
        vals[5 + 2 * p] = CFG_W'($urandom_range(0, 65535));
    end
    apply_cal(vals);
  endtask

  function logic [RAW_W-1:0] pick_raw(cmd_t cmd);
    logic [RAW_W-1:0] r0, r1;
    r0 = (cmd == CMD_TEMP) ? cal_words[REG_TEMP_RAW0] : cal_words[REG_HUM_RAW0];
    r1 = (cmd == CMD_TEMP) ? cal_words[REG_TEMP_RAW1] : cal_words[REG_HUM_RAW1];
    case ($urandom_range(0, 7))
      4: return RAW_W'(r0 + $urandom_range(0, 16) - 8);
      5: return RAW_W'(r1 + $urandom_range(0, 16) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      7: return RAW_W'((r0 < r1) ? $urandom_range(r0, r1) : $urandom_range(r1, r0));
      default: return RAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] vals [8];
    cmd_t cmd;
    sb = new();
    rst            = 1'b1;
    no_idle        = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wr_data    = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    foreach (cal_words[i]) cal_words[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // calibration after reset: both denominators zero
    send_sample(CMD_TEMP, 16'h0000);
    send_sample(CMD_HUM, 16'h7fff);
    send_sample(CMD_TEMP, 16'h8000);
    send_sample(CMD_HUM, 16'hffff);
    wait_drain();

    // typical calibration
    vals = '{16'd40, 16'd160, 16'd160, 16'd280, 16'hec78, 16'd10000, 16'd300, 16'hf830};
    apply_cal(vals);
    send_sample(CMD_TEMP, 16'h8000);
    send_sample(CMD_TEMP, 16'h7fff);
    send_sample(CMD_TEMP, 16'd300);
    send_sample(CMD_TEMP, 16'hf830);
    send_sample(CMD_HUM, 16'hec78);
    send_sample(CMD_HUM, 16'd10000);
    send_sample(CMD_HUM, 16'h0000);
    send_sample(CMD_HUM, 16'hffff);
    wait_drain();

    // widest reference span over the full raw range
    vals = '{16'd0, 16'd255, 16'd0, 16'd1023, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
    apply_cal(vals);
    send_sample(CMD_TEMP, 16'h8000);
    send_sample(CMD_TEMP, 16'h7fff);
    send_sample(CMD_HUM, 16'h8000);
    send_sample(CMD_HUM, 16'h7fff);
    wait_drain();

    // unit denominator drives saturation on temperature, equal humidity raws
    vals = '{16'd255, 16'd0, 16'd1023, 16'd0, 16'd12345, 16'd12345, 16'd0, 16'd1};
    apply_cal(vals);
    send_sample(CMD_TEMP, 16'h7fff);
    send_sample(CMD_TEMP, 16'h8000);
    send_sample(CMD_HUM, 16'd12345);
    wait_drain();

    // and the other way round
    vals = '{16'd255, 16'd0, 16'd1023, 16'd0, 16'hffff, 16'h0000, 16'h8000, 16'h8000};
    apply_cal(vals);
    send_sample(CMD_HUM, 16'h7fff);
    send_sample(CMD_HUM, 16'h8000);
    send_sample(CMD_TEMP, 16'h1234);
    wait_drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_cal();
      no_idle = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 149) == 0) begin
          in_chan.valid <= 1'b0;
          @(negedge clk);
          while (sb.pending() != 0) @(negedge clk);
        end
        cmd = cmd_t'($urandom_range(0, 1));
        send_sample(cmd, pick_raw(cmd));
      end
      no_idle = 1'b0;
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* humidity_temperature_calibration_top.f */
hdl/htc_pkg.sv
hdl/htc_stream_if.sv
hdl/htc_cal_regs.sv
hdl/htc_numer.sv
hdl/htc_divider.sv
hdl/htc_sat.sv
hdl/humidity_temperature_calibration_top.sv
verif/humidity_temperature_calibration_top_tb.sv
